// ----- rtl/core/pbu_pkg.sv -----
// pbu_pkg: shared types and constants of the planar image unpacker
// used by pbu_ctrl, pbu_dp and the top level; no dependencies
package pbu_pkg;

    localparam int LINES_DEF     = 200;
    localparam int ROW_BYTES_DEF = 40;
    localparam int PLANES_DEF    = 4;

    localparam int ADDR_W = 15;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 8;

    localparam logic [DATA_W-1:0] NOP_COUNT = 8'h80;
    localparam logic [CNT_W:0]    REP_BASE  = 9'd257;

    // decoder phase, plus the state that emits a repeat run
    typedef enum logic [2:0] {
        PH_COUNT,
        PH_REPEAT,
        PH_LITERAL,
        PH_SKIP,
        PH_RUN
    } t_phase;

    typedef struct packed {
        logic emit_raw;
        logic set_count;
        logic start_run;
        logic emit_lit;
        logic emit_run;
        logic skip_byte;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
        logic mode;
        logic out_free;
        logic byte_rep;
        logic byte_nop;
        logic rem_one;
        logic row_end;
    } t_dp_sts;

endpackage

// ----- rtl/core/pbu_ctrl.sv -----
// pbu_ctrl: phase state machine of the unpacker, drives pbu_dp commands
// depends on pbu_pkg
module pbu_ctrl
    import pbu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_stream_valid,
    output logic    o_stream_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_phase r_state;
    t_phase n_state;
    logic   accept;

    assign o_stream_ready = (r_state != PH_RUN) && i_sts.out_free;
    assign accept = i_stream_valid && o_stream_ready && !i_sts.finished;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_COUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (r_state == PH_RUN) begin
            if (i_sts.out_free && i_sts.rem_one) begin
                n_state = PH_COUNT;
            end
        end else if (accept && i_sts.mode) begin
            unique case (r_state)
                PH_COUNT: begin
                    if (!i_sts.byte_rep) begin
                        n_state = PH_LITERAL;
                    end else if (!i_sts.byte_nop) begin
                        n_state = PH_REPEAT;
                    end
                end
                PH_REPEAT: n_state = PH_RUN;
                PH_LITERAL: begin
                    priority if (i_sts.rem_one) begin
                        n_state = PH_COUNT;
                    end else if (i_sts.row_end) begin
                        n_state = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (i_sts.rem_one) begin
                        n_state = PH_COUNT;
                    end
                end
                default: n_state = r_state;
            endcase
        end
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        if (r_state == PH_RUN) begin
            o_cmd.emit_run = i_sts.out_free;
        end else if (accept) begin
            if (!i_sts.mode) begin
                o_cmd.emit_raw = 1'b1;
            end else begin
                unique case (r_state)
                    PH_COUNT:   o_cmd.set_count = !i_sts.byte_nop;
                    PH_REPEAT:  o_cmd.start_run = 1'b1;
                    PH_LITERAL: o_cmd.emit_lit  = 1'b1;
                    PH_SKIP:    o_cmd.skip_byte = 1'b1;
                    default:    o_cmd = '0;
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/pbu_dp.sv -----
// pbu_dp: counters, address generation, mode register and output register
// depends on pbu_pkg; commanded by pbu_ctrl
module pbu_dp
    import pbu_pkg::*;
#(
    parameter int LINES     = LINES_DEF,
    parameter int ROW_BYTES = ROW_BYTES_DEF,
    parameter int PLANES    = PLANES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_compressed_mode,
    input  logic [DATA_W-1:0] i_stream_byte,
    input  logic              i_write_ready,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_write_valid,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [DATA_W-1:0] o_write_data,
    output logic              o_last_of_run,
    output logic              o_run_clipped,
    output logic              o_picture_done
);

    localparam int COL_W   = $clog2(ROW_BYTES);
    localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int TOTAL   = LINES * ROW_BYTES * PLANES;
    localparam int TOT_W   = $clog2(TOTAL + 1);
    localparam int CMP_W   = (TOT_W > ADDR_W + 1) ? TOT_W : ADDR_W + 1;

    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    logic              r_mode;
    logic              r_finished;
    logic [CNT_W-1:0]  r_rem;
    logic [COL_W-1:0]  r_col;
    logic [PLANE_W-1:0] r_plane;
    logic [LINE_W-1:0] r_line;
    logic [ADDR_W-1:0] r_lin;
    logic [DATA_W-1:0] r_run_data;
    logic              r_run_clip;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              r_out_clip;
    logic              r_out_done;

    logic [CNT_W-1:0]  room;
    logic              lit_clip;
    logic              col_last;
    logic              plane_last;
    logic              line_last;
    logic              pic_end;
    logic              raw_done;
    logic [ADDR_W-1:0] cur_addr;
    logic              out_free;
    logic              advance;
    logic              emit;

    assign room       = CNT_W'(ROW_BYTES) - CNT_W'(r_col);
    assign lit_clip   = r_rem > room;
    assign col_last   = r_col == COL_W'(ROW_BYTES - 1);
    assign plane_last = r_plane == PLANE_W'(PLANES - 1);
    assign line_last  = r_line == LINE_W'(LINES - 1);
    assign pic_end    = col_last && plane_last && line_last;
    assign raw_done   = (CMP_W'(r_lin) + CMP_W'(1) >= CMP_W'(TOTAL)) || (r_lin == ADDR_MAX);

    // interleaved layout, taken modulo the address width
    assign cur_addr = ADDR_W'(r_line) * ADDR_W'(ROW_BYTES * PLANES)
                    + ADDR_W'(r_col >> 1) * ADDR_W'(2 * PLANES)
                    + ADDR_W'(r_plane) * ADDR_W'(2)
                    + ADDR_W'(r_col[0]);

    assign out_free = !r_out_valid || i_write_ready;
    assign advance  = i_cmd.emit_lit || i_cmd.emit_run;
    assign emit     = advance || i_cmd.emit_raw;

    assign o_sts.finished = r_finished;
    assign o_sts.mode     = r_mode;
    assign o_sts.out_free = out_free;
    assign o_sts.byte_rep = i_stream_byte[DATA_W-1];
    assign o_sts.byte_nop = i_stream_byte == NOP_COUNT;
    assign o_sts.rem_one  = r_rem == CNT_W'(1);
    assign o_sts.row_end  = col_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b1;
            r_finished  <= 1'b0;
            r_rem       <= '0;
            r_col       <= '0;
            r_plane     <= '0;
            r_line      <= '0;
            r_lin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_compressed_mode;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_write_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit_raw) begin
                if (raw_done) begin
                    r_finished <= 1'b1;
                end else begin
                    r_lin <= r_lin + ADDR_W'(1);
                end
            end
            if (i_cmd.set_count) begin
                if (i_stream_byte[DATA_W-1]) begin
                    r_rem <= CNT_W'(REP_BASE - {1'b0, i_stream_byte});
                end else begin
                    r_rem <= i_stream_byte + CNT_W'(1);
                end
            end
            if (i_cmd.start_run && lit_clip) begin
                r_rem <= room;
            end
            if (advance || i_cmd.skip_byte) begin
                r_rem <= r_rem - CNT_W'(1);
            end
            if (advance) begin
                if (!col_last) begin
                    r_col <= r_col + COL_W'(1);
                end else begin
                    r_col <= '0;
                    if (!plane_last) begin
                        r_plane <= r_plane + PLANE_W'(1);
                    end else begin
                        r_plane <= '0;
                        if (line_last) begin
                            r_finished <= 1'b1;
                        end else begin
                            r_line <= r_line + LINE_W'(1);
                        end
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run) begin
            r_run_data <= i_stream_byte;
            r_run_clip <= lit_clip;
        end
        if (i_cmd.emit_raw) begin
            r_out_addr <= r_lin;
            r_out_data <= i_stream_byte;
            r_out_last <= 1'b1;
            r_out_clip <= 1'b0;
            r_out_done <= raw_done;
        end else if (i_cmd.emit_lit) begin
            r_out_addr <= cur_addr;
            r_out_data <= i_stream_byte;
            r_out_last <= 1'b1;
            r_out_clip <= lit_clip;
            r_out_done <= pic_end;
        end else if (i_cmd.emit_run) begin
            r_out_addr <= cur_addr;
            r_out_data <= r_run_data;
            r_out_last <= r_rem == CNT_W'(1);
            r_out_clip <= r_run_clip;
            r_out_done <= pic_end;
        end
    end

    assign o_write_valid   = r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;
    assign o_last_of_run   = r_out_last;
    assign o_run_clipped   = r_out_clip;
    assign o_picture_done  = r_out_done;

endmodule

// ----- rtl/core/packbits_planar_image_unpacker.sv -----
// packbits_planar_image_unpacker: top level, joins controller and datapath
// depends on pbu_pkg, pbu_ctrl, pbu_dp
//
//   channel   direction  handshake                       payload
//   stream    in         i_stream_valid / o_stream_ready i_stream_byte
//   write     out        o_write_valid / i_write_ready   address, data, 3 flags
//   config    in         i_cfg_wr_en                     i_cfg_compressed_mode
//
// raw bytes, literal bytes, count bytes and skipped literals are each handled as they are accepted
// a repeat data byte is latched first, then written once per cycle while the write side is free,
// through the single output register, the run length being cut to the plane row
// a stalled write side holds the output register and blocks new requests
// synchronous reset clears all positions; compressed mode resets to 1
module packbits_planar_image_unpacker
    import pbu_pkg::*;
#(
    parameter int LINES     = LINES_DEF,
    parameter int ROW_BYTES = ROW_BYTES_DEF,
    parameter int PLANES    = PLANES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_compressed_mode,
    input  logic              i_stream_valid,
    output logic              o_stream_ready,
    input  logic [DATA_W-1:0] i_stream_byte,
    output logic              o_write_valid,
    input  logic              i_write_ready,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [DATA_W-1:0] o_write_data,
    output logic              o_last_of_run,
    output logic              o_run_clipped,
    output logic              o_picture_done
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pbu_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stream_valid (i_stream_valid),
        .o_stream_ready (o_stream_ready),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    pbu_dp #(
        .LINES     (LINES),
        .ROW_BYTES (ROW_BYTES),
        .PLANES    (PLANES)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_compressed_mode (i_cfg_compressed_mode),
        .i_stream_byte         (i_stream_byte),
        .i_write_ready         (i_write_ready),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .o_write_valid         (o_write_valid),
        .o_write_address       (o_write_address),
        .o_write_data          (o_write_data),
        .o_last_of_run         (o_last_of_run),
        .o_run_clipped         (o_run_clipped),
        .o_picture_done        (o_picture_done)
    );

endmodule

// ----- rtl/core/pbu_checker.sv -----
// pbu_checker: port-level assertions for the unpacker, bound to the top level
// depends on pbu_pkg
module pbu_checker
    import pbu_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_write_valid,
    input logic              i_write_ready,
    input logic [ADDR_W-1:0] o_write_address,
    input logic [DATA_W-1:0] o_write_data,
    input logic              o_last_of_run,
    input logic              o_picture_done
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_write_valid)
        else $error("write valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_valid && !i_write_ready |=>
            o_write_valid && $stable(o_write_address) && $stable(o_write_data))
        else $error("stalled write changed");

    // completion only ever falls on the final write of a request
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_valid && o_picture_done |-> o_last_of_run)
        else $error("picture done on a non-final write");

    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_valid && i_write_ready && o_picture_done |=> !o_write_valid)
        else $error("write after picture done");

endmodule

bind packbits_planar_image_unpacker pbu_checker u_pbu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_write_valid   (o_write_valid),
    .i_write_ready   (i_write_ready),
    .o_write_address (o_write_address),
    .o_write_data    (o_write_data),
    .o_last_of_run   (o_last_of_run),
    .o_picture_done  (o_picture_done)
);

// ----- tb/sv/packbits_planar_image_unpacker_test.sv -----
// packbits_planar_image_unpacker_test: self-checking bench for the planar image unpacker
// predicts every frame-buffer write from the byte stream and compares each accepted write
// depends on pbu_pkg and the packbits_planar_image_unpacker rtl
module packbits_planar_image_unpacker_test
    import pbu_pkg::*;
();

    localparam int ROW_LEN      = ROW_BYTES_DEF;
    localparam int PLANE_CNT    = PLANES_DEF;
    localparam int LINE_CNT     = LINES_DEF;
    localparam int RAW_TOTAL    = LINE_CNT * ROW_LEN * PLANE_CNT;
    localparam int ADDR_TOP     = (1 << ADDR_W) - 1;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_GAP   = 6;
    localparam int DRAIN_CYCLES = 50;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
        logic              clip;
        logic              done;
    } t_frame_write;

    // tracks the decoder position and the frame-buffer writes still owed
    class frame_write_tracker;
        t_frame_write pending_writes[$];
        logic         packed_mode;
        t_phase       phase;
        int           remaining;
        int           column;
        int           plane;
        int           line;
        int           lin_addr;
        bit           finished;
        int           mismatches;

        function void reset_state();
            pending_writes.delete();
            packed_mode = 1'b1;
            phase       = PH_COUNT;
            remaining   = 0;
            column      = 0;
            plane       = 0;
            line        = 0;
            lin_addr    = 0;
            finished    = 1'b0;
            mismatches  = 0;
        endfunction

        function logic [ADDR_W-1:0] plane_address();
            int a;
            a = line * ROW_LEN * PLANE_CNT + (column / 2) * 2 * PLANE_CNT
                + plane * 2 + (column % 2);
            return ADDR_W'(a);
        endfunction

        function void step_column(output bit row_end, output bit pic_done);
            row_end  = 1'b0;
            pic_done = 1'b0;
            column++;
            if (column >= ROW_LEN) begin
                row_end = 1'b1;
                column  = 0;
                plane++;
                if (plane >= PLANE_CNT) begin
                    plane = 0;
                    if (line + 1 >= LINE_CNT) begin
                        finished = 1'b1;
                        pic_done = 1'b1;
                    end else begin
                        line++;
                    end
                end
            end
        endfunction

        function void expect_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                                   bit last, bit clip, bit done);
            t_frame_write w;
            w.addr = addr;
            w.data = data;
            w.last = last;
            w.clip = clip;
            w.done = done;
            pending_writes.push_back(w);
        endfunction

        function void note_stream_byte(logic [DATA_W-1:0] b);
            int                room;
            int                n;
            bit                clip;
            bit                row_end;
            bit                pic_done;
            bit                done;
            logic [ADDR_W-1:0] addr;
            if (finished)
                return;
            if (!packed_mode) begin
                addr = ADDR_W'(lin_addr);
                done = (lin_addr + 1 >= RAW_TOTAL) || (lin_addr == ADDR_TOP);
                expect_write(addr, b, 1'b1, 1'b0, done);
                if (done)
                    finished = 1'b1;
                else
                    lin_addr = lin_addr + 1;
                return;
            end
            case (phase)
                PH_COUNT: begin
                    if (b[7]) begin
                        if (b != NOP_COUNT) begin
                            remaining = int'(REP_BASE) - int'(b);
                            phase     = PH_REPEAT;
                        end
                    end else begin
                        remaining = int'(b) + 1;
                        phase     = PH_LITERAL;
                    end
                end
                PH_REPEAT: begin
                    room = ROW_LEN - column;
                    n    = remaining;
                    clip = n > room;
                    if (clip)
                        n = room;
                    for (int i = 0; i < n; i++) begin
                        addr = plane_address();
                        step_column(row_end, pic_done);
                        expect_write(addr, b, i + 1 == n, clip, pic_done);
                        if (pic_done)
                            break;
                    end
                    remaining = 0;
                    phase     = PH_COUNT;
                end
                PH_LITERAL: begin
                    room = ROW_LEN - column;
                    clip = remaining > room;
                    addr = plane_address();
                    step_column(row_end, pic_done);
                    expect_write(addr, b, 1'b1, clip, pic_done);
                    remaining = (remaining - 1) & 8'hFF;
                    if (remaining == 0)
                        phase = PH_COUNT;
                    else if (row_end)
                        phase = PH_SKIP;
                end
                default: begin
                    // excess literals of a clipped run are swallowed
                    remaining = (remaining - 1) & 8'hFF;
                    if (remaining == 0)
                        phase = PH_COUNT;
                end
            endcase
        endfunction

        function void check_frame_write(t_frame_write got);
            t_frame_write want;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected write: addr %0d data %02h last %0b clip %0b done %0b",
                             got.addr, got.data, got.last, got.clip, got.done);
                return;
            end
            want = pending_writes.pop_front();
            if (got.addr !== want.addr || got.data !== want.data || got.last !== want.last
                || got.clip !== want.clip || got.done !== want.done) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("write mismatch: expected addr %0d data %02h last %0b clip %0b done %0b",
                             want.addr, want.data, want.last, want.clip, want.done);
                    $display("                actual   addr %0d data %02h last %0b clip %0b done %0b",
                             got.addr, got.data, got.last, got.clip, got.done);
                end
            end
        endfunction
    endclass

    logic              i_clk                 = 1'b0;
    logic              i_rst_n               = 1'b0;
    logic              i_cfg_wr_en           = 1'b0;
    logic              i_cfg_compressed_mode = 1'b1;
    logic              i_stream_valid        = 1'b0;
    logic              o_stream_ready;
    logic [DATA_W-1:0] i_stream_byte         = '0;
    logic              o_write_valid;
    logic              i_write_ready         = 1'b0;
    logic [ADDR_W-1:0] o_write_address;
    logic [DATA_W-1:0] o_write_data;
    logic              o_last_of_run;
    logic              o_run_clipped;
    logic              o_picture_done;

    frame_write_tracker book;
    t_frame_write       seen_write;
    bit                 tx_gaps      = 1'b0;
    bit                 rx_stalls    = 1'b0;
    bit                 hold_request = 1'b0;
    int                 bytes_sent   = 0;
    int                 cycle_count  = 0;

    packbits_planar_image_unpacker u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_compressed_mode (i_cfg_compressed_mode),
        .i_stream_valid        (i_stream_valid),
        .o_stream_ready        (o_stream_ready),
        .i_stream_byte         (i_stream_byte),
        .o_write_valid         (o_write_valid),
        .i_write_ready         (i_write_ready),
        .o_write_address       (o_write_address),
        .o_write_data          (o_write_data),
        .o_last_of_run         (o_last_of_run),
        .o_run_clipped         (o_run_clipped),
        .o_picture_done        (o_picture_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // write side: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_write_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                i_write_ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                i_write_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_write_valid && i_write_ready) begin
            seen_write.addr = o_write_address;
            seen_write.data = o_write_data;
            seen_write.last = o_last_of_run;
            seen_write.clip = o_run_clipped;
            seen_write.done = o_picture_done;
            book.check_frame_write(seen_write);
        end
    end

    function automatic logic [DATA_W-1:0] rep_count(input int run_len);
        return DATA_W'(int'(REP_BASE) - run_len);
    endfunction

    function automatic logic [DATA_W-1:0] lit_count(input int run_len);
        return DATA_W'(run_len - 1);
    endfunction

    // called and returns at a falling edge; valid stays high for the next request
    task automatic send_byte(input logic [DATA_W-1:0] b);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            i_stream_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_stream_valid <= 1'b1;
        i_stream_byte  <= b;
        do
            @(posedge i_clk);
        while (!o_stream_ready);
        book.note_stream_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_stream_valid <= 1'b0;
        while (book.pending_writes.size() != 0)
            @(posedge i_clk);
        // a trailing count byte may still be in flight
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_wr_en           <= 1'b1;
        i_cfg_compressed_mode <= mode;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        book.packed_mode = mode;
    endtask

    task automatic send_packet();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            send_byte(NOP_COUNT);
        end else if (sel < 50) begin
            send_byte(DATA_W'($urandom_range(8'h81, 8'hFF)));
            send_byte(DATA_W'($urandom_range(0, 255)));
        end else if (sel < 90) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16);
            send_byte(lit_count(len));
            repeat (len) send_byte(DATA_W'($urandom_range(0, 255)));
        end else begin
            // stray byte that breaks the sequence
            send_byte(DATA_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_packed(input int item_cnt, input bit with_hold);
        int stop_at;
        stop_at = bytes_sent + item_cnt;
        while (bytes_sent < stop_at) begin
            if (with_hold && bytes_sent + item_cnt - stop_at > 20 && !hold_request) begin
                hold_request = 1'b1;
                with_hold    = 1'b0;
            end
            send_packet();
        end
    endtask

    task automatic run_raw(input int item_cnt);
        repeat (item_cnt) send_byte(DATA_W'($urandom_range(0, 255)));
    endtask

    initial begin
        book = new();
        book.reset_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_mode(1'b1);

        // directed: no-op count, extreme counts, exact fit, clipped repeat and literal runs
        send_byte(NOP_COUNT);
        send_byte(rep_count(2));
        send_byte(8'h00);
        send_byte(rep_count(128));
        send_byte(8'hAA);
        send_byte(lit_count(1));
        send_byte(8'hFF);
        send_byte(rep_count(39));
        send_byte(8'h5A);
        send_byte(rep_count(36));
        send_byte(8'hC3);
        send_byte(lit_count(8));
        for (int i = 0; i < 8; i++)
            send_byte(DATA_W'(8'h11 * (i + 1)));
        send_byte(NOP_COUNT);
        settle();

        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_packed(100, 1'b1);
        settle();
        // random gaps and stalls stay on, without the long hold
        run_packed(20, 1'b0);
        settle();

        write_mode(1'b0);
        run_raw(50);
        settle();

        write_mode(1'b1);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_packed(60, 1'b0);
        settle();

        write_mode(1'b0);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_raw(30);
        settle();

        write_mode(1'b1);
        run_packed(40, 1'b0);
        settle();

        // no idling from here on
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_packed(40, 1'b0);
        i_stream_valid <= 1'b0;

        while (book.pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending_writes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
